FILE: rtl/core/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared constants for the segment / plane intersection block.
// ----------------------------------------------------------------------------
package spi_pkg;

   localparam int COORD_BITS_DEF = 16;   // default coordinate width (Q8.8)
   localparam int NORMAL_BITS    = 36;   // normal components, Q20.16
   localparam int OFFSET_BITS    = 54;   // plane offset, distance units
   localparam int THRESH_BITS    = 53;   // near threshold, distance units
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(17);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // register map
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORMAL_X     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORMAL_Y     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORMAL_Z     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_OFFSET = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEAR_THRESH  = 3'd4;

   // result classes
   localparam int CASE_BITS = 3;
   localparam logic [CASE_BITS-1:0] CASE_SAME_SIDE  = 3'd0;
   localparam logic [CASE_BITS-1:0] CASE_PROPER     = 3'd1;
   localparam logic [CASE_BITS-1:0] CASE_END_ON     = 3'd2;
   localparam logic [CASE_BITS-1:0] CASE_BEGIN_ON   = 3'd3;
   localparam logic [CASE_BITS-1:0] CASE_BOTH_ON    = 3'd4;

endpackage

FILE: rtl/core/spi_dist.sv
// ----------------------------------------------------------------------------
// spi_dist
// Signed distance n.p + d of one point, two register stages.
// ----------------------------------------------------------------------------
module spi_dist #(
   parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
   parameter int DIST_BITS  = 55
) (
   input  logic                                  clock,
   input  logic                                  adv,
   input  logic signed [COORD_BITS-1:0]          px,
   input  logic signed [COORD_BITS-1:0]          py,
   input  logic signed [COORD_BITS-1:0]          pz,
   input  logic signed [spi_pkg::NORMAL_BITS-1:0] nx,
   input  logic signed [spi_pkg::NORMAL_BITS-1:0] ny,
   input  logic signed [spi_pkg::NORMAL_BITS-1:0] nz,
   input  logic signed [spi_pkg::OFFSET_BITS-1:0] offset,
   output logic signed [DIST_BITS-1:0]           dist_out
);
   import spi_pkg::*;

   localparam int PW = NORMAL_BITS + COORD_BITS;

   logic signed [PW-1:0]        px_ff, py_ff, pz_ff;
   logic signed [DIST_BITS-1:0] dist_ff, dist_in;

   // stage 1: products
   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= nx * px;
         py_ff <= ny * py;
         pz_ff <= nz * pz;
      end
   end

   // stage 2: sum with offset
   assign dist_in = DIST_BITS'(px_ff) + DIST_BITS'(py_ff) + DIST_BITS'(pz_ff)
                  + DIST_BITS'(offset);

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff <= dist_in;
      end
   end

   assign dist_out = dist_ff;

endmodule

FILE: rtl/core/spi_div.sv
// ----------------------------------------------------------------------------
// spi_div
// Pipelined floor(a * b / s), one bit of a per stage, radix-2 digits 0..2.
// ----------------------------------------------------------------------------
module spi_div #(
   parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
   parameter int MAG_BITS   = 55
) (
   input  logic                  clock,
   input  logic                  adv,
   input  logic [COORD_BITS-1:0] a_in,
   input  logic [MAG_BITS-1:0]   b_in,
   input  logic [MAG_BITS:0]     s_in,
   output logic [COORD_BITS-1:0] q_out
);
   import spi_pkg::*;

   localparam int RW = MAG_BITS + 3;   // partial remainder before reduction

   // remainder stays below s, so MAG_BITS+1 bits hold it
   logic [MAG_BITS:0]     r_ff [COORD_BITS];
   logic [COORD_BITS-1:0] q_ff [COORD_BITS];
   logic [COORD_BITS-1:0] a_ff [COORD_BITS];
   logic [MAG_BITS-1:0]   b_ff [COORD_BITS];
   logic [MAG_BITS:0]     s_ff [COORD_BITS];

   for (genvar k = 0; k < COORD_BITS; k++) begin : g_step
      logic [MAG_BITS:0]     r_src;
      logic [COORD_BITS-1:0] q_src, a_src;
      logic [MAG_BITS-1:0]   b_src;
      logic [MAG_BITS:0]     s_src;
      logic [RW-1:0]         r2, s1, s2, r_in;
      logic [1:0]            digit;

      if (k == 0) begin : g_first
         assign r_src = '0;
         assign q_src = '0;
         assign a_src = a_in;
         assign b_src = b_in;
         assign s_src = s_in;
      end else begin : g_next
         assign r_src = r_ff[k-1];
         assign q_src = q_ff[k-1];
         assign a_src = a_ff[k-1];
         assign b_src = b_ff[k-1];
         assign s_src = s_ff[k-1];
      end

      always_comb begin
         r2 = {1'b0, r_src, 1'b0} + (a_src[COORD_BITS-1] ? RW'(b_src) : '0);
         s1 = RW'(s_src);
         s2 = {1'b0, s_src, 1'b0};
         priority if (r2 >= s2) begin
            r_in  = r2 - s2;
            digit = 2'd2;
         end else if (r2 >= s1) begin
            r_in  = r2 - s1;
            digit = 2'd1;
         end else begin
            r_in  = r2;
            digit = 2'd0;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[k] <= r_in[MAG_BITS:0];
            q_ff[k] <= (q_src << 1) + COORD_BITS'(digit);
            a_ff[k] <= a_src << 1;
            b_ff[k] <= b_src;
            s_ff[k] <= s_src;
         end
      end
   end

   assign q_out = q_ff[COORD_BITS-1];

endmodule

FILE: rtl/core/segment_plane_intersect.sv
// ----------------------------------------------------------------------------
// segment_plane_intersect
// Segment against plane test with pipelined crossing point interpolation.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  req_     in   tdata: begin_x, begin_y, begin_z, end_x, end_y, end_z
//  rsp_     out  tuser: crossed, cross_case; tdata: cross_x, cross_y, cross_z
//  csr_     in   csr_index, csr_wdata; always ready
//
//  One beat per cycle sustained while rsp_ does not stall; the pipeline is the
//  distance stages (2), the classify stage (1), one divider stage per
//  coordinate bit and the output register.
//  Synchronous active-high reset clears valid bits and restores registers.
//  A stall on rsp_ freezes the whole pipeline; nothing is lost or repeated.
//  Coordinates carry any fraction width: the distance scale follows it.
// ----------------------------------------------------------------------------
module segment_plane_intersect #(
   parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // request: begin_x, begin_y, begin_z, end_x, end_y, end_z (lowest first)
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [((6*COORD_BITS+7)/8)*8-1:0]             req_tdata,
   // response tdata: cross_x, cross_y, cross_z (lowest first)
   // response tuser: crossed [0], cross_case [3:1]
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [((3*COORD_BITS+7)/8)*8-1:0]             rsp_tdata,
   output logic [3:0]                                    rsp_tuser,
   // register writes
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [spi_pkg::CSR_INDEX_BITS-1:0]            csr_index,
   input  logic [spi_pkg::CSR_DATA_BITS-1:0]             csr_wdata
);
   import spi_pkg::*;

   localparam int C        = COORD_BITS;
   localparam int OUT_BITS = ((3*C+7)/8)*8;
   // distance: three N+C products plus offset
   localparam int SUM_BITS = NORMAL_BITS + C + 2;
   localparam int DW       = ((SUM_BITS > OFFSET_BITS) ? SUM_BITS : OFFSET_BITS) + 1;
   localparam int MW       = DW;
   localparam int TW       = (MW > THRESH_BITS) ? MW : THRESH_BITS;
   localparam int DEPTH    = C + 3;   // distance(2) + classify(1) + divider(C)

   typedef struct packed {
      logic [2:0][C-1:0]     b;
      logic [2:0][C-1:0]     e;
      logic [2:0]            neg;
      logic                  crossed;
      logic [CASE_BITS-1:0]  kase;
   } side_type;

   // ---- configuration ----
   logic signed [NORMAL_BITS-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [OFFSET_BITS-1:0] off_ff;
   logic        [THRESH_BITS-1:0] thr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff  <= '0;
         ny_ff  <= '0;
         nz_ff  <= '0;
         off_ff <= '0;
         thr_ff <= THRESH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NORMAL_X:     nx_ff  <= csr_wdata[NORMAL_BITS-1:0];
            CSR_NORMAL_Y:     ny_ff  <= csr_wdata[NORMAL_BITS-1:0];
            CSR_NORMAL_Z:     nz_ff  <= csr_wdata[NORMAL_BITS-1:0];
            CSR_PLANE_OFFSET: off_ff <= csr_wdata[OFFSET_BITS-1:0];
            CSR_NEAR_THRESH:  thr_ff <= csr_wdata[THRESH_BITS-1:0];
            default: ;   // unmapped index, dropped
         endcase
      end
   end

   // ---- flow control: whole pipe moves when the output slot frees ----
   logic adv;
   logic rsp_valid_ff;
   logic [DEPTH-1:0] vld_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;

   // ---- unpack request beat ----
   logic signed [C-1:0] bx, by, bz, ex, ey, ez;
   assign bx = req_tdata[0*C +: C];
   assign by = req_tdata[1*C +: C];
   assign bz = req_tdata[2*C +: C];
   assign ex = req_tdata[3*C +: C];
   assign ey = req_tdata[4*C +: C];
   assign ez = req_tdata[5*C +: C];

   // ---- distances (stages 1-2) ----
   logic signed [DW-1:0] d1, d2;

   spi_dist #(.COORD_BITS(C), .DIST_BITS(DW)) u_dist_begin (
      .clock(clock), .adv(adv), .px(bx), .py(by), .pz(bz),
      .nx(nx_ff), .ny(ny_ff), .nz(nz_ff), .offset(off_ff), .dist_out(d1)
   );

   spi_dist #(.COORD_BITS(C), .DIST_BITS(DW)) u_dist_end (
      .clock(clock), .adv(adv), .px(ex), .py(ey), .pz(ez),
      .nx(nx_ff), .ny(ny_ff), .nz(nz_ff), .offset(off_ff), .dist_out(d2)
   );

   // ---- classify (stage 3) ----
   side_type            side_ff [DEPTH];
   side_type            side0_in, cls_in;
   logic [MW-1:0]       m1, m2, m1_ff;
   logic [MW:0]         sum_in, sum_ff;
   logic                big1, big2;
   logic [2:0][C-1:0]   dmag_in, dmag_ff;

   always_comb begin
      side0_in         = '0;
      side0_in.b       = {bz, by, bx};
      side0_in.e       = {ez, ey, ex};
   end

   assign m1     = d1[DW-1] ? MW'(~d1 + 1'b1) : MW'(d1);
   assign m2     = d2[DW-1] ? MW'(~d2 + 1'b1) : MW'(d2);
   assign sum_in = {1'b0, m1} + {1'b0, m2};
   assign big1   = TW'(m1) > TW'(thr_ff);
   assign big2   = TW'(m2) > TW'(thr_ff);

   always_comb begin
      logic signed [C:0] delta;
      cls_in = side_ff[1];
      for (int i = 0; i < 3; i++) begin
         delta = {cls_in.e[i][C-1], cls_in.e[i]} - {cls_in.b[i][C-1], cls_in.b[i]};
         cls_in.neg[i] = delta[C];
         dmag_in[i]    = delta[C] ? C'(-delta) : delta[C-1:0];
      end
      priority if (big1 && big2) begin
         cls_in.crossed = d1[DW-1] != d2[DW-1];
         cls_in.kase    = (d1[DW-1] != d2[DW-1]) ? CASE_PROPER : CASE_SAME_SIDE;
      end else if (big1) begin
         cls_in.crossed = 1'b1;
         cls_in.kase    = CASE_END_ON;
      end else if (big2) begin
         cls_in.crossed = 1'b1;
         cls_in.kase    = CASE_BEGIN_ON;
      end else begin
         cls_in.crossed = 1'b0;
         cls_in.kase    = CASE_BOTH_ON;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff   <= m1;
         sum_ff  <= sum_in;
         dmag_ff <= dmag_in;
      end
   end

   // ---- sideband and valid delay line ----
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DEPTH; k++) begin
            if (k == 0)      side_ff[k] <= side0_in;
            else if (k == 2) side_ff[k] <= cls_in;
            else             side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[DEPTH-2:0], req_tvalid};
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   // ---- interpolation: q = |delta| * |d1| / (|d1| + |d2|) per axis ----
   logic [2:0][C-1:0] q;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      spi_div #(.COORD_BITS(C), .MAG_BITS(MW)) u_div (
         .clock(clock), .adv(adv), .a_in(dmag_ff[i]), .b_in(m1_ff),
         .s_in(sum_ff), .q_out(q[i])
      );
   end

   // ---- final select and output register ----
   side_type          fin;
   logic [2:0][C-1:0] pt_in, pt_ff;
   logic              crossed_ff;
   logic [CASE_BITS-1:0] kase_ff;

   assign fin = side_ff[DEPTH-1];

   always_comb begin
      logic [C:0] acc;
      for (int i = 0; i < 3; i++) begin
         acc = fin.neg[i] ? ({fin.b[i][C-1], fin.b[i]} - {1'b0, q[i]})
                          : ({fin.b[i][C-1], fin.b[i]} + {1'b0, q[i]});
         unique case (fin.kase)
            CASE_PROPER:   pt_in[i] = acc[C-1:0];
            CASE_END_ON:   pt_in[i] = fin.e[i];
            CASE_BEGIN_ON: pt_in[i] = fin.b[i];
            default:       pt_in[i] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff      <= pt_in;
         crossed_ff <= fin.crossed;
         kase_ff    <= fin.kase;
      end
   end

   assign rsp_tdata = OUT_BITS'(pt_ff);
   assign rsp_tuser = {kase_ff, crossed_ff};

endmodule
